[src/tts_pkg.sv]
package tts_pkg;

    localparam int MaxRows = 64;
    localparam int IdxW    = 6;
    localparam int CntW    = 7;
    localparam int DivStepW = 6;

    localparam logic signed [31:0] QMax = 32'sh7fffffff;
    localparam logic signed [31:0] QMin = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] off_diag;
        logic signed [31:0] diag;
        logic signed [31:0] rhs;
        logic               last_row;
    } row_t;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [IdxW-1:0]    row_index;
        logic               last;
        logic               div_error;
    } sol_t;

    // Row handed from the front to the back, with its index and final mark
    typedef struct packed {
        logic signed [31:0] off_diag;
        logic signed [31:0] diag;
        logic signed [31:0] rhs;
        logic [IdxW-1:0]    idx;
        logic               fin;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDPREV,
        ST_MULA,
        ST_MULB,
        ST_DIVA,
        ST_DIVB,
        ST_WRITE,
        ST_BRD,
        ST_BMUL,
        ST_BSUM,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // Q16.16 product, floor shift, saturate
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [47:0] q;
        begin
            p = a * b;
            q = p[63:16];
            if (q > 48'sh00007fffffff)
                qmul = QMax;
            else if (q < -48'sh000080000000)
                qmul = QMin;
            else
                qmul = q[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        begin
            if (v > 33'sh07fffffff)
                sat33 = QMax;
            else if (v < -33'sh080000000)
                sat33 = QMin;
            else
                sat33 = v[31:0];
        end
    endfunction

endpackage

[src/tts_if.sv]
interface tts_row_if;
    logic           valid;
    logic           ready;
    tts_pkg::row_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tts_sol_if;
    logic           valid;
    logic           ready;
    tts_pkg::sol_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/tridiagonal_thomas_solver_top.sv]
// Channel | Dir | Payload
// rows    | in  | off_diag, diag, rhs, last_row
// sols    | out | solution, row_index, last, div_error
// In the back end each row runs two 49-step divisions on one shared restoring
// divider. Back substitution reads, multiplies and sums for each row; emission
// reads each result, then offers it. A two-entry queue takes rows meanwhile.
// Reset is asynchronous; no memory clearing is needed.
module tridiagonal_thomas_solver_top (
    input  logic     clk,
    input  logic     rst_n,
    tts_row_if.sink  rows,
    tts_sol_if.source sols
);
    logic           job_valid, job_ready;
    tts_pkg::job_t  job;

    tts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    tts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .sols      (sols)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sols.valid && !sols.ready |=> sols.valid && $stable(sols.payload))
        else $error("result dropped while stalled");
    a_qfull: assert property (@(posedge clk) disable iff (!rst_n)
        !rows.ready |-> job_valid)
        else $error("queue full without pending job");
endmodule

[src/tts_front.sv]
module tts_front (
    input  logic           clk,
    input  logic           rst_n,
    tts_row_if.sink        rows,
    output logic           job_valid,
    input  logic           job_ready,
    output tts_pkg::job_t  job
);
    // Two-entry queue of classified rows
    tts_pkg::job_t             q_reg [2];
    logic [1:0]                cnt_reg, cnt_next;
    logic                      rd_reg, rd_next;
    logic [tts_pkg::CntW-1:0]  row_reg, row_next;
    tts_pkg::job_t             in_job;
    logic                      push, pop;

    assign rows.ready = (cnt_reg != 2'd2);
    assign push       = rows.valid && rows.ready;
    assign job_valid  = (cnt_reg != 2'd0);
    assign pop        = job_valid && job_ready;
    assign job        = q_reg[rd_reg];

    always_comb
    begin
        in_job.off_diag = rows.payload.off_diag;
        in_job.diag     = rows.payload.diag;
        in_job.rhs      = rows.payload.rhs;
        in_job.idx      = row_reg[tts_pkg::IdxW-1:0];
        in_job.fin      = rows.payload.last_row ||
                          (row_reg == tts_pkg::CntW'(tts_pkg::MaxRows - 1));
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = pop ? ~rd_reg : rd_reg;
        row_next = row_reg;
        if (push)
        begin
            row_next = in_job.fin ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[rd_reg ^ cnt_reg[0]] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            row_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            row_reg <= row_next;
        end
    end
endmodule

[src/tts_div.sv]
// Restoring divider: (num << 16) / den, 33-bit signed operands, one bit a cycle
module tts_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [32:0]  num,
    input  logic signed [32:0]  den,
    output logic                done,
    output logic signed [31:0]  quo,
    output logic                zero
);
    localparam int DW = tts_pkg::DivStepW;

    logic [48:0] rem_reg, rem_next;
    logic [48:0] q_reg, q_next;
    logic [32:0] d_reg;
    logic        neg_reg, nneg_reg, zero_reg;
    logic [DW-1:0] step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [49:0] trial;
    logic [48:0] nmag;
    logic [32:0] nabs;
    logic signed [50:0] sq;

    always_comb
    begin
        nabs  = num[32] ? 33'(-num) : 33'(num);
        nmag  = {nabs, 16'd0};
        trial = {rem_reg, q_reg[48]} - {17'd0, d_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            q_next    = nmag;
            step_next = '0;
            busy_next = (den != 0);
        end
        else if (busy_reg)
        begin
            if (!trial[49])
            begin
                rem_next = trial[48:0];
                q_next   = {q_reg[47:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[47:0], q_reg[48]};
                q_next   = {q_reg[47:0], 1'b0};
            end
            // one quotient bit per cycle, 49 in all
            step_next = step_reg + 1'b1;
        end
    end

    // step_reg runs 0..48 using a 6-bit counter; finish at 48
    logic fin_step;
    assign fin_step = busy_reg && (step_reg == DW'(48));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg    <= den[32] ? 33'(-den) : 33'(den);
            neg_reg  <= num[32] ^ den[32];
            nneg_reg <= num[32];
            zero_reg <= (den == 0);
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= fin_step ? 1'b0 : busy_next;
            done_reg <= fin_step || (start && den == 0);
        end
    end

    always_comb
    begin
        sq = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        if (zero_reg)
            quo = nneg_reg ? tts_pkg::QMin : tts_pkg::QMax;
        else if (sq > 51'sh7fffffff)
            quo = tts_pkg::QMax;
        else if (sq < -51'sh80000000)
            quo = tts_pkg::QMin;
        else
            quo = sq[31:0];
    end
    assign done = done_reg;
    assign zero = zero_reg;
endmodule

[src/tts_back.sv]
module tts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  tts_pkg::job_t  job,
    tts_sol_if.source      sols
);
    localparam int IW = tts_pkg::IdxW;

    logic signed [31:0] alpha_mem [tts_pkg::MaxRows];
    logic signed [31:0] beta_mem  [tts_pkg::MaxRows];
    logic signed [31:0] sol_mem   [tts_pkg::MaxRows];

    tts_pkg::state_t state_reg, state_next;
    tts_pkg::job_t   cur_reg;
    logic signed [31:0] pa_reg, pb_reg, ma_reg, mb_reg;
    logic signed [32:0] d_reg;
    logic signed [31:0] alpha_reg, x_reg, bk_reg, ak_reg, prod_reg;
    logic [IW-1:0]      k_reg, k_next, n1_reg;
    logic               err_reg;
    logic signed [31:0] sol_rd_reg;

    logic               div_start, div_done, div_zero;
    logic signed [32:0] div_num;
    logic signed [32:0] div_den;
    logic signed [31:0] div_quo;
    logic signed [32:0] d_comb;

    tts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .zero  (div_zero)
    );

    // Divisor is formed exactly in 33 bits
    assign d_comb = (cur_reg.idx == '0) ? 33'(cur_reg.diag) :
                    33'(ma_reg) + 33'(cur_reg.diag);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tts_pkg::ST_IDLE:    if (job_valid) state_next = tts_pkg::ST_RDPREV;
            tts_pkg::ST_RDPREV:  state_next = tts_pkg::ST_MULA;
            tts_pkg::ST_MULA:    state_next = tts_pkg::ST_MULB;
            tts_pkg::ST_MULB:    state_next = tts_pkg::ST_DIVA;
            tts_pkg::ST_DIVA:    if (div_done) state_next = tts_pkg::ST_DIVB;
            tts_pkg::ST_DIVB:    if (div_done) state_next = tts_pkg::ST_WRITE;
            tts_pkg::ST_WRITE:   state_next = cur_reg.fin ? ((cur_reg.idx == '0) ?
                                     tts_pkg::ST_EMIT_RD : tts_pkg::ST_BRD) :
                                     tts_pkg::ST_IDLE;
            tts_pkg::ST_BRD:     state_next = tts_pkg::ST_BMUL;
            tts_pkg::ST_BMUL:    state_next = tts_pkg::ST_BSUM;
            tts_pkg::ST_BSUM:    state_next = (k_reg == IW'(1)) ?
                                     tts_pkg::ST_EMIT_RD : tts_pkg::ST_BRD;
            tts_pkg::ST_EMIT_RD: state_next = tts_pkg::ST_EMIT;
            tts_pkg::ST_EMIT:    if (sols.ready)
                                     state_next = (k_reg == n1_reg) ?
                                         tts_pkg::ST_IDLE : tts_pkg::ST_EMIT_RD;
            default:             state_next = tts_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = (state_reg == tts_pkg::ST_IDLE);
        div_start = 1'b0;
        div_num   = 33'(-$signed({cur_reg.off_diag[31], cur_reg.off_diag}));
        div_den   = d_reg;
        if (state_reg == tts_pkg::ST_MULB)
        begin
            div_start = 1'b1;
            div_den   = d_comb;
        end
        else if (state_reg == tts_pkg::ST_DIVA && div_done)
        begin
            div_start = 1'b1;
            div_num   = (cur_reg.idx == '0) ? 33'(cur_reg.rhs) :
                        33'(cur_reg.rhs) - 33'(mb_reg);
        end
        sols.valid             = (state_reg == tts_pkg::ST_EMIT);
        sols.payload.solution  = sol_rd_reg;
        sols.payload.row_index = k_reg;
        sols.payload.last      = (k_reg == n1_reg);
        sols.payload.div_error = err_reg;
    end

    always_comb
    begin
        k_next = k_reg;
        unique case (state_reg)
            tts_pkg::ST_WRITE: k_next = cur_reg.fin ? ((cur_reg.idx == '0) ? '0 :
                                   cur_reg.idx) : k_reg;
            tts_pkg::ST_BSUM:  k_next = (k_reg == IW'(1)) ? '0 : k_reg - 1'b1;
            tts_pkg::ST_EMIT:  k_next = sols.ready ? k_reg + 1'b1 : k_reg;
            default:           k_next = k_reg;
        endcase
    end

    // Memories and datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == tts_pkg::ST_IDLE && job_valid)
        begin
            cur_reg <= job;
        end
        if (state_reg == tts_pkg::ST_RDPREV)
        begin
            pa_reg <= alpha_mem[cur_reg.idx - 1'b1];
            pb_reg <= beta_mem[cur_reg.idx - 1'b1];
        end
        if (state_reg == tts_pkg::ST_MULA)
        begin
            ma_reg <= tts_pkg::qmul(cur_reg.off_diag, pa_reg);
            mb_reg <= tts_pkg::qmul(cur_reg.off_diag, pb_reg);
        end
        if (state_reg == tts_pkg::ST_MULB)
        begin
            d_reg <= d_comb;
        end
        if (state_reg == tts_pkg::ST_DIVA && div_done)
        begin
            alpha_reg <= div_quo;
        end
        if (state_reg == tts_pkg::ST_DIVB && div_done)
        begin
            alpha_mem[cur_reg.idx] <= alpha_reg;
            beta_mem[cur_reg.idx]  <= div_quo;
            if (cur_reg.fin)
            begin
                sol_mem[cur_reg.idx] <= div_quo;
                x_reg <= div_quo;
            end
        end
        if (state_reg == tts_pkg::ST_WRITE)
        begin
            n1_reg <= cur_reg.idx;
        end
        if (state_reg == tts_pkg::ST_BRD)
        begin
            ak_reg <= alpha_mem[k_reg - 1'b1];
            bk_reg <= beta_mem[k_reg - 1'b1];
        end
        if (state_reg == tts_pkg::ST_BMUL)
        begin
            prod_reg <= tts_pkg::qmul(x_reg, ak_reg);
        end
        if (state_reg == tts_pkg::ST_BSUM)
        begin
            x_reg <= tts_pkg::sat33(33'(prod_reg) + 33'(bk_reg));
            sol_mem[k_reg - 1'b1] <= tts_pkg::sat33(33'(prod_reg) + 33'(bk_reg));
        end
        if (state_reg == tts_pkg::ST_EMIT_RD)
        begin
            sol_rd_reg <= sol_mem[k_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tts_pkg::ST_IDLE;
            k_reg     <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if ((state_reg == tts_pkg::ST_DIVA || state_reg == tts_pkg::ST_DIVB)
                && div_done && div_zero)
            begin
                err_reg <= 1'b1;
            end
            else if (state_reg == tts_pkg::ST_EMIT && sols.ready && k_reg == n1_reg)
            begin
                err_reg <= 1'b0;
            end
        end
    end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 400;

    class thomas_scoreboard;
        longint alpha[tts_pkg::MaxRows];
        longint beta[tts_pkg::MaxRows];
        longint xval[tts_pkg::MaxRows];
        int     rows_in;
        bit     zero_div;
        tts_pkg::sol_t pending[$];
        int     systems;
        int     error_systems;

        function new();
            rows_in = 0;
            zero_div = 0;
            systems = 0;
            error_systems = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(tts_pkg::QMax))
                return longint'(tts_pkg::QMax);
            if (v < longint'(tts_pkg::QMin))
                return longint'(tts_pkg::QMin);
            return v;
        endfunction

        // floor shift of the full product
        function longint fx_mul(longint a, longint b);
            longint p;
            p = a * b;
            return clamp32(p >>> 16);
        endfunction

        function longint fx_div(longint num, longint den);
            if (den == 0)
            begin
                zero_div = 1;
                return (num < 0) ? longint'(tts_pkg::QMin) : longint'(tts_pkg::QMax);
            end
            return clamp32((num * 65536) / den);
        endfunction

        function void note_row(tts_pkg::row_t r);
            longint a;
            longint c;
            longint f;
            longint d;
            int     i;
            bit     fin;
            tts_pkg::sol_t s;
            a = longint'(r.off_diag);
            c = longint'(r.diag);
            f = longint'(r.rhs);
            i = rows_in;
            fin = r.last_row;
            if (i >= tts_pkg::MaxRows - 1)
            begin
                i = tts_pkg::MaxRows - 1;
                fin = 1;
            end
            if (i == 0)
            begin
                alpha[0] = fx_div(-a, c);
                beta[0] = fx_div(f, c);
            end
            else
            begin
                d = fx_mul(a, alpha[i-1]) + c;
                alpha[i] = fx_div(-a, d);
                beta[i] = fx_div(f - fx_mul(a, beta[i-1]), d);
            end
            if (!fin)
            begin
                rows_in = i + 1;
                return;
            end
            xval[i] = beta[i];
            for (int k = i; k > 0; k--)
                xval[k-1] = clamp32(fx_mul(xval[k], alpha[k-1]) + beta[k-1]);
            for (int k = 0; k <= i; k++)
            begin
                s.solution = xval[k][31:0];
                s.row_index = k[tts_pkg::IdxW-1:0];
                s.last = (k == i);
                s.div_error = zero_div;
                pending.insert(pending.size(), s);
            end
            systems++;
            if (zero_div)
                error_systems++;
            rows_in = 0;
            zero_div = 0;
        endfunction

        function bit check(tts_pkg::sol_t got, output string msg);
            tts_pkg::sol_t e;
            if (pending.size() == 0)
            begin
                msg = $sformatf("unexpected result x=%h idx=%0d", got.solution, got.row_index);
                return 0;
            end
            e = pending.pop_front();
            if (got.solution !== e.solution || got.row_index !== e.row_index
                || got.last !== e.last || got.div_error !== e.div_error)
            begin
                msg = $sformatf("idx %0d: got x=%h i=%0d l=%b e=%b, want x=%h i=%0d l=%b e=%b",
                                e.row_index, got.solution, got.row_index, got.last,
                                got.div_error, e.solution, e.row_index, e.last, e.div_error);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    tts_row_if rows ();
    tts_sol_if sols ();

    tridiagonal_thomas_solver_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rows  (rows.sink),
        .sols  (sols.source)
    );

    thomas_scoreboard sb;
    int  mismatches;
    int  rows_sent;
    int  results_seen;
    int  cycles;
    bit  burst;

    initial clk = 0;
    always #10 clk = ~clk;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // toggle between stretches with random gaps and back-to-back stretches
    always
    begin
        repeat (300) @(posedge clk);
        burst = ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && rows.valid && rows.ready)
        begin
            sb.note_row(rows.payload);
            rows_sent++;
        end
        if (rst_n && sols.valid && sols.ready)
        begin
            results_seen++;
            if (!sb.check(sols.payload, msg))
                report(msg);
        end
    end

    // result side stalls
    initial
    begin
        int w;
        sols.ready = 0;
        @(posedge rst_n);
        forever
        begin
            w = burst ? 0 : $urandom_range(0, 17);
            if (w > 0)
            begin
                sols.ready <= 0;
                repeat (w) @(posedge clk);
            end
            sols.ready <= 1;
            @(posedge clk);
            while (!(sols.valid && sols.ready))
                @(posedge clk);
        end
    end

    task automatic drive_row(tts_pkg::row_t r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            rows.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        rows.valid <= 1;
        rows.payload <= r;
        @(posedge clk);
        while (!rows.ready)
            @(posedge clk);
    endtask

    function automatic tts_pkg::row_t mk_row(logic [31:0] a, logic [31:0] c,
                                             logic [31:0] f, bit fin);
        tts_pkg::row_t r;
        r.off_diag = a;
        r.diag = c;
        r.rhs = f;
        r.last_row = fin;
        return r;
    endfunction

    // mostly diagonally dominant rows so the solution stays in range
    function automatic tts_pkg::row_t rand_row(bit fin);
        logic signed [31:0] a;
        logic signed [31:0] c;
        logic signed [31:0] f;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            a = $signed($urandom_range(0, 32'h0001ffff)) - 32'sh00010000;
            c = $signed($urandom_range(32'h00030000, 32'h00080000));
            if ($urandom_range(0, 1))
                c = -c;
            f = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
        end
        else if (kind < 18)
        begin
            a = $urandom;
            c = $urandom;
            f = $urandom;
        end
        else
        begin
            a = $urandom;
            c = 0;
            f = $urandom;
        end
        return mk_row(a, c, f, fin);
    endfunction

    task automatic drive_system(int n, bit force_len);
        for (int k = 0; k < n; k++)
            drive_row(rand_row(force_len ? 1'b0 : (k == n - 1)));
    endtask

    initial
    begin
        sb = new();
        mismatches = 0;
        rows_sent = 0;
        results_seen = 0;
        cycles = 0;
        burst = 0;
        rst_n = 0;
        rows.valid = 0;
        rows.payload = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single rows, zero divisors of each numerator sign, extremes
        drive_row(mk_row(32'h00010000, 32'h00020000, 32'h00030000, 1));
        drive_row(mk_row(32'h00010000, 32'h00000000, 32'h00030000, 1));
        drive_row(mk_row(32'h00010000, 32'h00000000, 32'hfffd0000, 1));
        drive_row(mk_row(32'h00000000, 32'h00000000, 32'h00000000, 1));
        drive_row(mk_row(tts_pkg::QMax, tts_pkg::QMin, tts_pkg::QMax, 1));
        drive_row(mk_row(tts_pkg::QMin, 32'h00000001, tts_pkg::QMax, 1));
        drive_row(mk_row(tts_pkg::QMax, 32'hffffffff, tts_pkg::QMin, 1));
        drive_row(mk_row(32'h00000000, tts_pkg::QMax, tts_pkg::QMin, 1));
        // three rows with extreme off-diagonals
        drive_row(mk_row(tts_pkg::QMax, 32'h00040000, 32'h00010000, 0));
        drive_row(mk_row(tts_pkg::QMin, 32'h00040000, tts_pkg::QMax, 0));
        drive_row(mk_row(tts_pkg::QMax, tts_pkg::QMin, tts_pkg::QMin, 1));
        // second divisor cancels to zero
        drive_row(mk_row(32'h00010000, 32'h00010000, 32'h00020000, 0));
        drive_row(mk_row(32'h00010000, 32'h00010000, 32'h00050000, 1));
        // ordinary two and four row systems
        drive_row(mk_row(32'h00008000, 32'h00030000, 32'h00010000, 0));
        drive_row(mk_row(32'hffff8000, 32'hfffd0000, 32'h00020000, 1));
        drive_system(4, 0);
        // full-length system with no final mark: final forced at the last index
        drive_system(tts_pkg::MaxRows, 1);
        drive_system(tts_pkg::MaxRows, 0);

        while (rows_sent < 300)
        begin
            if ($urandom_range(0, 39) == 0)
                drive_system(tts_pkg::MaxRows, $urandom_range(0, 1));
            else
                drive_system($urandom_range(1, 6), 0);
        end
        rows.valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (sb.pending.size() != 0)
            report($sformatf("%0d results never arrived", sb.pending.size()));

        $display("rows %0d, systems %0d (%0d with zero divisor), results %0d",
                 rows_sent, sb.systems, sb.error_systems, results_seen);
        $display("mismatches %0d", mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
